>>> rtl/hmwf_pkg.sv
// Shared constants, codes and control types of the harmonic mean window filter.
`default_nettype none
package hmwf_pkg;

    localparam int TAPS     = 3;
    localparam int TAP_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int POS_W    = 12;
    localparam int SUM_W    = 32;
    localparam int BLEND_W  = 9;
    localparam int NUM_COEF = 5;
    localparam int ADDR_W   = 5;
    localparam int TDATA_W  = 128;

    localparam int DIV_NW   = 33;
    localparam int DIV_DW   = 35;
    localparam int DIV_CW   = 6;
    localparam int ACC_W    = 36;
    localparam int CRIT_W   = 42;

    localparam logic [2:0] REG_COEF_0 = 3'd0;
    localparam logic [2:0] REG_COEF_1 = 3'd1;
    localparam logic [2:0] REG_COEF_2 = 3'd2;
    localparam logic [2:0] REG_COEF_3 = 3'd3;
    localparam logic [2:0] REG_COEF_4 = 3'd4;
    localparam logic [2:0] REG_SPAN   = 3'd5;
    localparam logic [2:0] REG_BLEND  = 3'd6;

    localparam logic [COEF_W-1:0]  COEF_0_RST = 16'd16384;
    localparam logic [COEF_W-1:0]  COEF_1_RST = 16'd32768;
    localparam logic [COEF_W-1:0]  COEF_2_RST = 16'd16384;
    localparam logic [COEF_W-1:0]  COEF_3_RST = 16'd0;
    localparam logic [COEF_W-1:0]  COEF_4_RST = 16'd0;
    localparam logic [POS_W-1:0]   SPAN_RST   = 12'd100;
    localparam logic [BLEND_W-1:0] BLEND_RST  = 9'd128;
    localparam logic [BLEND_W-1:0] BLEND_MAX  = 9'd256;

    localparam logic [1:0] F_ZERO = 2'd0;
    localparam logic [1:0] F_SAT  = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;

    localparam logic [1:0] DIV_TERM  = 2'd0;
    localparam logic [1:0] DIV_RECIP = 2'd1;
    localparam logic [1:0] DIV_MEAN  = 2'd2;

    typedef struct packed {
        logic             load;
        logic             div_start;
        logic [1:0]       div_sel;
        logic [TAP_W-1:0] tap;
        logic             sum_clear;
        logic             term_add;
        logic             accum;
        logic [1:0]       f_code;
        logic             p_sel;
        logic             crit_mul1;
        logic             crit_mul2;
        logic             out_load;
        logic             finish;
    } hmwf_cmd_t;

    typedef struct packed {
        logic has_prev;
        logic is_final;
        logic at_edge;
        logic win_zero;
        logic sum_zero;
        logic div_done;
    } hmwf_status_t;

endpackage
`default_nettype wire

>>> rtl/hmwf_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none
module hmwf_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [hmwf_pkg::DIV_NW-1:0] dividend,
    input  wire logic [hmwf_pkg::DIV_DW-1:0] divisor,
    output logic      [hmwf_pkg::DIV_NW-1:0] quotient,
    output logic                             done
);
    import hmwf_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] dsr_reg, dsr_next;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_NW);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = DIV_DW'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[DIV_DW-1:0];
            end
            quo_next = {quo_reg[DIV_NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("divider done without work");
`endif

endmodule
`default_nettype wire

>>> rtl/hmwf_dp.sv
// Datapath of the filter: registers, window, accumulators, divider and result register.
`default_nettype none
module hmwf_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [hmwf_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    input  wire logic [hmwf_pkg::SAMPLE_W-1:0] s_tdata,
    input  wire hmwf_pkg::hmwf_cmd_t          cmd,
    output hmwf_pkg::hmwf_status_t            status,
    output logic      [hmwf_pkg::TDATA_W-1:0] out_tdata,
    output logic                              out_fault,
    output logic                              out_last
);
    import hmwf_pkg::*;

    logic        [COEF_W-1:0]   coef_reg [NUM_COEF];
    logic        [POS_W-1:0]    span_reg;
    logic        [BLEND_W-1:0]  blend_reg;
    logic signed [SAMPLE_W-1:0] win_reg [TAPS];
    logic        [POS_W-1:0]    idx_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic        [SUM_W-1:0]    var_reg, var_next;
    logic        [SUM_W-1:0]    dev_reg, dev_next;
    logic signed [ACC_W-1:0]    sum_reg;
    logic                       neg_reg;
    logic        [CRIT_W-1:0]   crit_reg;
    logic        [TDATA_W-1:0]  tdata_reg, tdata_next;
    logic                       fault_reg;
    logic                       last_reg;

    logic        [POS_W-1:0]    p_val;
    logic        [TAP_W-1:0]    win_sel;
    logic signed [SAMPLE_W-1:0] tap_s;
    logic        [SAMPLE_W:0]   tap_mag;
    logic        [ACC_W-1:0]    sum_mag;
    logic        [DIV_NW-1:0]   div_n;
    logic        [DIV_DW-1:0]   div_d;
    logic                       div_neg;
    logic        [DIV_NW-1:0]   quo;
    logic                       div_done;
    logic        [ACC_W-1:0]    quo_ext;
    logic signed [SAMPLE_W-1:0] recip_f;
    logic signed [SAMPLE_W-1:0] f_val;
    logic signed [SAMPLE_W:0]   dv, dd;
    logic        [SAMPLE_W:0]   dv_abs, dd_abs;
    logic signed [SAMPLE_W-1:0] dev_ref;
    logic        [SUM_W:0]      var_add, dev_add;
    logic        [BLEND_W-1:0]  b_eff;
    logic        [CRIT_W-2:0]   prod;
    logic        [CRIT_W-9:0]   crit_shift;
    logic        [SUM_W-1:0]    crit_sat;
    logic                       cfg_wr;
    logic                       is_last;

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= COEF_0_RST;
            coef_reg[1] <= COEF_1_RST;
            coef_reg[2] <= COEF_2_RST;
            coef_reg[3] <= COEF_3_RST;
            coef_reg[4] <= COEF_4_RST;
            span_reg    <= SPAN_RST;
            blend_reg   <= BLEND_RST;
        end else if (cfg_wr) begin
            unique case (paddr[ADDR_W-1:2])
                REG_COEF_0: coef_reg[0] <= pwdata[COEF_W-1:0];
                REG_COEF_1: coef_reg[1] <= pwdata[COEF_W-1:0];
                REG_COEF_2: coef_reg[2] <= pwdata[COEF_W-1:0];
                REG_COEF_3: coef_reg[3] <= pwdata[COEF_W-1:0];
                REG_COEF_4: coef_reg[4] <= pwdata[COEF_W-1:0];
                REG_SPAN:   span_reg    <= pwdata[POS_W-1:0];
                REG_BLEND:  blend_reg   <= pwdata[BLEND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_COEF_0: prdata = 32'(coef_reg[0]);
            REG_COEF_1: prdata = 32'(coef_reg[1]);
            REG_COEF_2: prdata = 32'(coef_reg[2]);
            REG_COEF_3: prdata = 32'(coef_reg[3]);
            REG_COEF_4: prdata = 32'(coef_reg[4]);
            REG_SPAN:   prdata = 32'(span_reg);
            REG_BLEND:  prdata = 32'(blend_reg);
            default:    prdata = '0;
        endcase
    end

    // Status toward the controller.
    assign p_val = cmd.p_sel ? idx_reg : idx_reg - 1'b1;
    assign status.has_prev = idx_reg != '0;
    assign status.is_final = idx_reg == span_reg;
    assign status.at_edge  = (p_val == '0) || (p_val >= span_reg);
    assign status.win_zero = (win_reg[0] == '0) || (win_reg[1] == '0) || (win_reg[2] == '0);
    assign status.sum_zero = sum_reg == '0;
    assign status.div_done = div_done;

    // Divider operand selection.
    assign win_sel = TAP_W'(TAPS - 1) - cmd.tap;
    assign tap_s   = win_reg[win_sel];
    assign tap_mag = tap_s[SAMPLE_W-1] ? (SAMPLE_W+1)'(-{tap_s[SAMPLE_W-1], tap_s})
                                       : {1'b0, tap_s};
    assign sum_mag = sum_reg[ACC_W-1] ? ACC_W'(-sum_reg) : ACC_W'(sum_reg);

    always_comb begin
        case (cmd.div_sel)
            DIV_TERM: begin
                div_n   = {1'b0, coef_reg[3'(cmd.tap)], 16'd0};
                div_d   = DIV_DW'(tap_mag);
                div_neg = tap_s[SAMPLE_W-1];
            end
            DIV_RECIP: begin
                div_n   = {1'b1, 32'd0};
                div_d   = sum_mag[DIV_DW-1:0];
                div_neg = sum_reg[ACC_W-1];
            end
            default: begin
                div_n   = {1'b0, dev_reg};
                div_d   = (span_reg == '0) ? DIV_DW'(1) : DIV_DW'(span_reg);
                div_neg = 1'b0;
            end
        endcase
    end

    hmwf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (quo),
        .done     (div_done)
    );

    // Result value and error measures.
    assign quo_ext = ACC_W'(quo);

    always_comb begin
        if (!neg_reg) begin
            recip_f = (quo > DIV_NW'(32767)) ? 16'sd32767 : $signed(quo[SAMPLE_W-1:0]);
        end else begin
            recip_f = (quo > DIV_NW'(32768)) ? -16'sd32768
                                             : $signed(SAMPLE_W'(0) - quo[SAMPLE_W-1:0]);
        end
        case (cmd.f_code)
            F_SAT:   f_val = 16'sd32767;
            F_DIV:   f_val = recip_f;
            default: f_val = '0;
        endcase
    end

    assign dev_ref = cmd.p_sel ? win_reg[0] : win_reg[1];
    assign dv      = {f_val[SAMPLE_W-1], f_val} - {prev_reg[SAMPLE_W-1], prev_reg};
    assign dd      = {f_val[SAMPLE_W-1], f_val} - {dev_ref[SAMPLE_W-1], dev_ref};
    assign dv_abs  = dv[SAMPLE_W] ? (SAMPLE_W+1)'(-dv) : dv;
    assign dd_abs  = dd[SAMPLE_W] ? (SAMPLE_W+1)'(-dd) : dd;
    assign var_add = {1'b0, var_reg} + (SUM_W+1)'(dv_abs);
    assign dev_add = {1'b0, dev_reg} + (SUM_W+1)'(dd_abs);
    assign var_next = var_add[SUM_W] ? '1 : var_add[SUM_W-1:0];
    assign dev_next = dev_add[SUM_W] ? '1 : dev_add[SUM_W-1:0];

    assign b_eff = (blend_reg > BLEND_MAX) ? BLEND_MAX : blend_reg;
    always_comb begin
        if (cmd.crit_mul1) begin
            prod = (CRIT_W-1)'(b_eff) * (CRIT_W-1)'(var_reg);
        end else begin
            prod = (CRIT_W-1)'(BLEND_MAX - b_eff) * (CRIT_W-1)'(quo[SUM_W-1:0]);
        end
    end
    assign crit_shift = crit_reg[CRIT_W-1:8];
    assign crit_sat   = (crit_shift[CRIT_W-9:SUM_W] != '0) ? '1 : crit_shift[SUM_W-1:0];
    assign is_last    = status.is_final && cmd.p_sel;

    always_comb begin
        tdata_next                  = '0;
        tdata_next[POS_W-1:0]       = p_val;
        tdata_next[27:POS_W]        = f_val;
        if (is_last) begin
            tdata_next[59:28]  = var_reg;
            tdata_next[91:60]  = quo[SUM_W-1:0];
            tdata_next[123:92] = crit_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < TAPS; t++) begin
                win_reg[t] <= '0;
            end
            idx_reg   <= '0;
            prev_reg  <= '0;
            var_reg   <= '0;
            dev_reg   <= '0;
            fault_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                for (int t = TAPS - 1; t > 0; t--) begin
                    win_reg[t] <= win_reg[t-1];
                end
                win_reg[0] <= $signed(s_tdata);
            end
            if (cmd.accum) begin
                var_reg  <= var_next;
                dev_reg  <= dev_next;
                prev_reg <= f_val;
            end
            if (cmd.out_load) begin
                fault_reg <= cmd.f_code == F_SAT;
                last_reg  <= is_last;
            end
            if (cmd.finish) begin
                if (status.is_final) begin
                    idx_reg  <= '0;
                    prev_reg <= '0;
                    var_reg  <= '0;
                    dev_reg  <= '0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
        if (cmd.div_start) begin
            neg_reg <= div_neg;
        end
        if (cmd.sum_clear) begin
            sum_reg <= '0;
        end else if (cmd.term_add) begin
            sum_reg <= neg_reg ? sum_reg - $signed(quo_ext) : sum_reg + $signed(quo_ext);
        end
        if (cmd.crit_mul1) begin
            crit_reg <= CRIT_W'(prod);
        end else if (cmd.crit_mul2) begin
            crit_reg <= crit_reg + CRIT_W'(prod);
        end
        if (cmd.out_load) begin
            tdata_reg <= tdata_next;
        end
    end

    assign out_tdata = tdata_reg;
    assign out_fault = fault_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

>>> rtl/hmwf_ctrl.sv
// Controller state machine that sequences the datapath and the result handshake.
`default_nettype none
module hmwf_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire hmwf_pkg::hmwf_status_t status,
    output hmwf_pkg::hmwf_cmd_t         cmd
);
    import hmwf_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PLAN    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_TERM    = 4'd3;
    localparam logic [3:0] S_TERM_W  = 4'd4;
    localparam logic [3:0] S_RECIP   = 4'd5;
    localparam logic [3:0] S_RECIP_W = 4'd6;
    localparam logic [3:0] S_ACCUM   = 4'd7;
    localparam logic [3:0] S_MEAN    = 4'd8;
    localparam logic [3:0] S_MEAN_W  = 4'd9;
    localparam logic [3:0] S_CRIT1   = 4'd10;
    localparam logic [3:0] S_CRIT2   = 4'd11;
    localparam logic [3:0] S_EMIT    = 4'd12;
    localparam logic [3:0] S_FINISH  = 4'd13;

    logic [3:0]       state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic             p_sel_reg, p_sel_next;
    logic [1:0]       f_code_reg, f_code_next;
    logic             out_valid_reg, out_valid_next;

    always_comb begin
        state_next  = state_reg;
        tap_next    = tap_reg;
        p_sel_next  = p_sel_reg;
        f_code_next = f_code_reg;
        cmd         = '0;
        cmd.tap     = tap_reg;
        cmd.p_sel   = p_sel_reg;
        cmd.f_code  = f_code_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PLAN;
                end
            end
            S_PLAN: begin
                if (status.has_prev) begin
                    p_sel_next = 1'b0;
                    state_next = S_CHECK;
                end else if (status.is_final) begin
                    p_sel_next = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_CHECK: begin
                if (status.at_edge) begin
                    f_code_next = F_ZERO;
                    state_next  = S_ACCUM;
                end else if (status.win_zero) begin
                    f_code_next = F_SAT;
                    state_next  = S_ACCUM;
                end else begin
                    cmd.sum_clear = 1'b1;
                    tap_next      = '0;
                    state_next    = S_TERM;
                end
            end
            S_TERM: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TERM;
                state_next    = S_TERM_W;
            end
            S_TERM_W: begin
                if (status.div_done) begin
                    cmd.term_add = 1'b1;
                    if (tap_reg == TAP_W'(TAPS - 1)) begin
                        state_next = S_RECIP;
                    end else begin
                        tap_next   = tap_reg + 1'b1;
                        state_next = S_TERM;
                    end
                end
            end
            S_RECIP: begin
                if (status.sum_zero) begin
                    f_code_next = F_SAT;
                    state_next  = S_ACCUM;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_RECIP;
                    state_next    = S_RECIP_W;
                end
            end
            S_RECIP_W: begin
                if (status.div_done) begin
                    f_code_next = F_DIV;
                    state_next  = S_ACCUM;
                end
            end
            S_ACCUM: begin
                cmd.accum = 1'b1;
                if (status.is_final && p_sel_reg) begin
                    state_next = S_MEAN;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_MEAN: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
                state_next    = S_MEAN_W;
            end
            S_MEAN_W: begin
                if (status.div_done) begin
                    state_next = S_CRIT1;
                end
            end
            S_CRIT1: begin
                cmd.crit_mul1 = 1'b1;
                state_next    = S_CRIT2;
            end
            S_CRIT2: begin
                cmd.crit_mul2 = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    if (!p_sel_reg && status.is_final) begin
                        p_sel_next = 1'b1;
                        state_next = S_CHECK;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            p_sel_reg     <= 1'b0;
            f_code_reg    <= F_ZERO;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            p_sel_reg     <= p_sel_next;
            f_code_reg    <= f_code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before transfer");
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_PLAN))
        else $error("accepted sample did not start processing");
`endif

endmodule
`default_nettype wire

>>> rtl/harmonic_mean_window_filter.sv
// An edge or zero-sample position shows its result without any division; an interior
// position runs each of the three tap divisions and then the reciprocal on the shared
// 33-bit divider, one after another (a zero sum skips the reciprocal division).
// A new sample is taken only after the controller has finished with the previous one;
// the final sample adds the mean division and the blend.
// Reset is synchronous and active low; it restores register defaults and clears state.
`default_nettype none
module harmonic_mean_window_filter (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [hmwf_pkg::SAMPLE_W-1:0]        s_tdata,  // sample
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // position, filtered, total_variation, mean_deviation, criterion, zero fill
    output logic      [hmwf_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                      m_tuser,  // div_fault
    output logic                                      m_tlast,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [hmwf_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [31:0]                          pwdata,
    output logic      [31:0]                          prdata,
    output logic                                      pready
);
    import hmwf_pkg::*;

    hmwf_cmd_t    cmd;
    hmwf_status_t status;

    assign pready = 1'b1;

    hmwf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hmwf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_tdata (m_tdata),
        .out_fault (m_tuser),
        .out_last  (m_tlast)
    );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the harmonic mean window filter: directed table plus random runs.
module tb_top;
    import hmwf_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [POS_W-1:0]    pos;
        logic [SAMPLE_W-1:0] filt;
        logic                fault;
        logic                last;
        logic [SUM_W-1:0]    tv;
        logic [SUM_W-1:0]    md;
        logic [SUM_W-1:0]    crit;
    } hm_result_t;

    typedef struct {
        logic [SAMPLE_W-1:0] smp;
        bit                  chk;
        logic [SAMPLE_W-1:0] filt;
        logic                fault;
    } drow_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    harmonic_mean_window_filter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Filter model state and register copy.
    logic [COEF_W-1:0]          coef_r [NUM_COEF];
    logic [POS_W-1:0]           span_r;
    logic [BLEND_W-1:0]         blend_r;
    logic signed [SAMPLE_W-1:0] win [TAPS];
    logic [POS_W-1:0]           idx;
    int                         prev_out;
    logic [SUM_W-1:0]           var_sum;
    logic [SUM_W-1:0]           dev_sum;

    hm_result_t expected_q[$];
    int         errors = 0;
    int         snd_idle = 0;
    int         rcv_idle = 0;
    int         quiet = 0;
    int         items = 0;

    task automatic report(input string what, input longint got, input longint exp);
        $display("mismatch %s: got %0h expected %0h", what, got, exp);
        errors++;
    endtask

    function automatic int win_at(input int off);
        if (off < 0 || off >= TAPS) return 0;
        return win[off];
    endfunction

    function automatic int harmonic(input int p, input int i, output bit flt);
        longint sum, q;
        int s;
        flt = 0;
        sum = 0;
        if (p < 1 || p > int'(span_r) - 1) return 0;
        for (int t = 0; t < TAPS; t++) begin
            s = win_at(i - p + 1 - t);
            if (s == 0) begin
                flt = 1;
                return 32767;
            end
            sum += (longint'(coef_r[t]) * 65536) / longint'(s);
        end
        if (sum == 0) begin
            flt = 1;
            return 32767;
        end
        q = (64'sd1 <<< 32) / sum;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a, input int d);
        longint unsigned s;
        s = longint'(a) + longint'(d < 0 ? -d : d);
        return s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic predict_filter(input logic [SAMPLE_W-1:0] smp);
        int i, k, lo, hi, f;
        bit flt, fin;
        hm_result_t r;
        longint unsigned dv, mean, b, crit;
        for (int d = TAPS - 1; d > 0; d--) win[d] = win[d-1];
        win[0] = smp;
        i = idx;
        k = span_r;
        fin = (i == k);
        lo = (i >= 1) ? i - 1 : 0;
        hi = fin ? k : i - 1;
        for (int p = lo; p <= hi; p++) begin
            f = harmonic(p, i, flt);
            var_sum = sat_add(var_sum, f - prev_out);
            dev_sum = sat_add(dev_sum, f - win_at(i - p));
            prev_out = f;
            r.pos = p[POS_W-1:0];
            r.filt = f[15:0];
            r.fault = flt;
            r.last = fin && p == k;
            r.tv = '0;
            r.md = '0;
            r.crit = '0;
            if (r.last) begin
                dv = (span_r != 0) ? span_r : 1;
                mean = dev_sum / dv;
                b = (blend_r > BLEND_MAX) ? BLEND_MAX : blend_r;
                crit = (b * var_sum + (256 - b) * mean) / 256;
                r.tv = var_sum;
                r.md = mean[31:0];
                r.crit = crit > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : crit[31:0];
            end
            expected_q.insert(expected_q.size(), r);
        end
        if (fin) begin
            idx = '0;
            prev_out = 0;
            var_sum = '0;
            dev_sum = '0;
        end else begin
            idx = idx + 1'b1;
        end
    endtask

    task automatic apb_write(input logic [2:0] reg_id, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(reg_id) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_id < NUM_COEF) coef_r[reg_id] = val[COEF_W-1:0];
        else if (reg_id == REG_SPAN) span_r = val[POS_W-1:0];
        else if (reg_id == REG_BLEND) blend_r = val[BLEND_W-1:0];
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Returns the queue depth before the sample, so a caller can find its first result.
    task automatic send_sample(input logic [SAMPLE_W-1:0] v, output int base);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        base = expected_q.size();
        predict_filter(v);
        items++;
        if (items == 140) begin
            snd_idle = 72;
            rcv_idle = 38;
        end else if (items == 280) begin
            snd_idle = 0;
            rcv_idle = 0;
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(49);
        if (r == 0) return '0;
        if (r == 1) return 16'h8000;
        if (r == 2) return 16'h7FFF;
        if (r == 3) return 16'h0001;
        if (r == 4) return 16'hFFFF;
        return $urandom_range(16'hFFFF);
    endfunction

    function automatic logic [31:0] rand_coef();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return 32'hFFFF;
        return $urandom_range(16'hFFFF);
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge aclk) begin
        hm_result_t e;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report("unexpected transfer", m_tdata[POS_W-1:0], 0);
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[11:0] !== e.pos) report("position", m_tdata[11:0], e.pos);
                if (m_tdata[27:12] !== e.filt) report("filtered", m_tdata[27:12], e.filt);
                if (m_tuser !== e.fault) report("div_fault", m_tuser, e.fault);
                if (m_tlast !== e.last) report("last", m_tlast, e.last);
                if (m_tdata[59:28] !== e.tv) report("total_variation", m_tdata[59:28], e.tv);
                if (m_tdata[91:60] !== e.md) report("mean_deviation", m_tdata[91:60], e.md);
                if (m_tdata[123:92] !== e.crit) report("criterion", m_tdata[123:92], e.crit);
                if (m_tdata[127:124] !== 4'd0) report("fill", m_tdata[127:124], 0);
            end
        end
    end

    drow_t dtab[20] = '{
        '{16'h1000, 0, 16'h0000, 0}, '{16'h1000, 1, 16'h0000, 0},
        '{16'h1000, 1, 16'h1000, 0}, '{16'h1000, 1, 16'h1000, 0},
        '{16'h1000, 1, 16'h1000, 0},
        '{16'h1000, 0, 16'h0000, 0}, '{16'h0000, 1, 16'h0000, 0},
        '{16'h1000, 1, 16'h7FFF, 1}, '{16'h1000, 1, 16'h7FFF, 1},
        '{16'h1000, 0, 16'h0000, 0},
        '{16'h7FFF, 0, 16'h0000, 0}, '{16'h8000, 0, 16'h0000, 0},
        '{16'h0001, 0, 16'h0000, 0}, '{16'hFFFF, 0, 16'h0000, 0},
        '{16'h7FFF, 0, 16'h0000, 0},
        '{16'h0001, 0, 16'h0000, 0}, '{16'h0001, 0, 16'h0000, 0},
        '{16'h0001, 1, 16'h0001, 0}, '{16'h0001, 1, 16'h0001, 0},
        '{16'h0001, 0, 16'h0000, 0}
    };

    initial begin
        int base, len, r;
        coef_r[0] = COEF_0_RST;
        coef_r[1] = COEF_1_RST;
        coef_r[2] = COEF_2_RST;
        coef_r[3] = COEF_3_RST;
        coef_r[4] = COEF_4_RST;
        span_r = SPAN_RST;
        blend_r = BLEND_RST;
        for (int d = 0; d < TAPS; d++) win[d] = '0;
        idx = '0;
        prev_out = 0;
        var_sum = '0;
        dev_sum = '0;
        snd_idle = 38;
        rcv_idle = 72;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        apb_write(REG_SPAN, 4095);
        apb_write(REG_SPAN, 4);
        foreach (dtab[n]) begin
            send_sample(dtab[n].smp, base);
            if (dtab[n].chk) begin
                if (expected_q.size() <= base) report("table row", n, 0);
                else if (expected_q[base].filt !== dtab[n].filt
                         || expected_q[base].fault !== dtab[n].fault)
                    report("table row filtered", expected_q[base].filt, dtab[n].filt);
            end
        end
        wait_drained();
        for (int c = 0; c < NUM_COEF; c++) apb_write(c[2:0], 0);
        apb_write(REG_BLEND, 511);
        for (int n = 0; n < 5; n++) send_sample(16'h1000, base);
        wait_drained();
        apb_write(REG_SPAN, 0);
        apb_write(REG_BLEND, 0);
        for (int n = 0; n < 2; n++) send_sample(16'h2000, base);
        wait_drained();
        while (items < 410) begin
            if ($urandom_range(3) != 0) begin
                r = $urandom_range(99);
                if (r < 70) len = $urandom_range(9, 4);
                else if (r < 85) len = $urandom_range(3);
                else len = $urandom_range(30, 10);
                apb_write(REG_SPAN, len);
                for (int c = 0; c < 3; c++) apb_write(c[2:0], rand_coef());
                if ($urandom_range(3) == 0) begin
                    apb_write(REG_COEF_3, rand_coef());
                    apb_write(REG_COEF_4, rand_coef());
                end
                r = $urandom_range(5);
                apb_write(REG_BLEND, r == 0 ? 0 : r == 1 ? 256 : r == 2 ? 511
                                     : $urandom_range(256));
            end
            for (int n = 0; n <= span_r; n++) begin
                send_sample(rand_sample(), base);
                if (items == 200) begin
                    @(posedge aclk);
                    s_tvalid <= 1'b0;
                    while (expected_q.size() != 0) @(posedge aclk);
                end
            end
            wait_drained();
        end
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> harmonic_mean_window_filter.f
rtl/hmwf_pkg.sv
rtl/hmwf_div.sv
rtl/hmwf_dp.sv
rtl/hmwf_ctrl.sv
rtl/harmonic_mean_window_filter.sv
tb/tb_top.sv
